// ===== rtl/core/sspmd_pkg.sv =====
// shared types and constants of the soft-start pwm motor driver
`timescale 1ns / 1ps
`default_nettype none

package sspmd_pkg;

    // field widths
    localparam int unsigned FUNC_W   = 3;
    localparam int unsigned SECS_W   = 8;
    localparam int unsigned DUTY_W   = 7;
    localparam int unsigned DIR_W    = 2;
    localparam int unsigned PERIOD_W = 10;
    localparam int unsigned STEP_W   = 10;
    localparam int unsigned MS_W     = 18;

    // serial arithmetic widths
    localparam int unsigned MUL_A_W = MS_W;
    localparam int unsigned MUL_B_W = DUTY_W;
    localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int unsigned DIV_N_W = MUL_P_W;
    localparam int unsigned DIV_D_W = MS_W;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 1'b1;

    // request function codes
    localparam logic [FUNC_W-1:0] FN_PWM  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_RAMP = 3'd1;
    localparam logic [FUNC_W-1:0] FN_FWD  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_BWD  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_STOP = 3'd4;

    // direction pin patterns
    localparam logic [DIR_W-1:0] DIR_OFF = 2'b00;
    localparam logic [DIR_W-1:0] DIR_FWD = 2'b01;
    localparam logic [DIR_W-1:0] DIR_BWD = 2'b10;

    localparam logic [DUTY_W-1:0]   DUTY_MAX   = 7'd100;
    localparam logic [DIV_D_W-1:0]  PCT_DIV    = 18'd100;
    localparam logic [PERIOD_W-1:0] PERIOD_RST = 10'd33;
    localparam logic [STEP_W-1:0]   STEP_RST   = 10'd100;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              channel;
        logic [SECS_W-1:0] ramp_seconds;
        logic [DUTY_W-1:0] duty_limit;
    } req_t;

    typedef struct packed {
        logic              pwm_a;
        logic              pwm_b;
        logic [DIR_W-1:0]  dir_a;
        logic [DIR_W-1:0]  dir_b;
        logic [DUTY_W-1:0] duty_a;
        logic [DUTY_W-1:0] duty_b;
    } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/core/sspmd_mul.sv =====
// bit-serial shift-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module sspmd_mul (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [sspmd_pkg::MUL_A_W-1:0]   a,
    input  logic [sspmd_pkg::MUL_B_W-1:0]   b,
    output logic                            done,
    output logic [sspmd_pkg::MUL_P_W-1:0]   product
);
    import sspmd_pkg::*;

    localparam int unsigned CNT_W = $clog2(MUL_B_W + 1);
    localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(MUL_B_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [MUL_A_W-1:0]   a_reg;
    logic [MUL_P_W-1:0]   prod_reg;
    logic [MUL_A_W:0]     sum;

    // add the multiplicand when the low bit of the shifting multiplier is set
    assign sum = {1'b0, prod_reg[MUL_P_W-1:MUL_B_W]}
               + {1'b0, (prod_reg[0] ? a_reg : {MUL_A_W{1'b0}})};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            // one-cycle pulse after the last multiplier bit
            done_reg <= !start && busy_reg && (cnt_reg == CNT_LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_LOAD;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_LAST;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg    <= a;
            prod_reg <= {{MUL_A_W{1'b0}}, b};
        end
        else if (busy_reg)
        begin
            prod_reg <= {sum, prod_reg[MUL_B_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

`default_nettype wire

// ===== rtl/core/sspmd_div.sv =====
// restoring serial divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module sspmd_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [sspmd_pkg::DIV_N_W-1:0]   dividend,
    input  logic [sspmd_pkg::DIV_D_W-1:0]   divisor,
    output logic                            done,
    output logic [sspmd_pkg::DIV_N_W-1:0]   quotient
);
    import sspmd_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIV_N_W + 1);
    localparam logic [CNT_W-1:0] CNT_LOAD = CNT_W'(DIV_N_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [DIV_D_W-1:0]   div_reg;
    logic [DIV_D_W-1:0]   rem_reg;
    logic [DIV_N_W-1:0]   quo_reg;
    logic [DIV_D_W:0]     shifted;
    logic [DIV_D_W+1:0]   diff;
    logic                 borrow;

    // bring down the next dividend bit and try the subtraction
    assign shifted = {rem_reg, quo_reg[DIV_N_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, div_reg};
    assign borrow  = diff[DIV_D_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            // one-cycle pulse after the last quotient bit
            done_reg <= !start && busy_reg && (cnt_reg == CNT_LAST);
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_LOAD;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_LAST;
                if (cnt_reg == CNT_LAST)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= borrow ? shifted[DIV_D_W-1:0] : diff[DIV_D_W-1:0];
            quo_reg <= {quo_reg[DIV_N_W-2:0], ~borrow};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/core/soft_start_pwm_motor_driver_top.sv =====
// top level of the soft-start pwm motor driver: sequencer and channel state
//
// channel | signals                            | direction | meaning
// --------+------------------------------------+-----------+--------------------------------
// req     | req_valid req_ready req_data       | in        | pwm tick, ramp tick, start, stop
// rsp     | rsp_valid rsp_ready rsp_data       | out       | pin, direction and duty snapshot
// cfg     | cfg_valid cfg_ready cfg_index/data | in        | period and ramp step registers
//
// pwm tick, forward, backward, stop and unused codes: handled in the idle cycle that takes
//   the request; the result is registered from the done state once the output register is free
// ramp tick: per active channel a serial multiply then a serial divide, and when the duty
//   changes the pwm threshold is recomputed the same way
// period write: rebuilds the thresholds of every channel, no requests taken
// reset clears all channel state, no clearing pass; a waiting result does not block
//   the next request, only the delivery of its result
`timescale 1ns / 1ps
`default_nettype none

module soft_start_pwm_motor_driver_top #(
    parameter int unsigned CHANNELS = 2
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_ready,
    input  sspmd_pkg::req_t                      req_data,
    output logic                                 rsp_valid,
    input  logic                                 rsp_ready,
    output sspmd_pkg::rsp_t                      rsp_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [sspmd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sspmd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import sspmd_pkg::*;

    localparam int unsigned CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned B_IDX = (CHANNELS > 1) ? 1 : 0;
    localparam bit          HAS_B = (CHANNELS > 1);
    localparam logic [CH_W-1:0] CH_LAST = CH_W'(CHANNELS - 1);
    localparam logic [CH_W-1:0] CH_ONE  = CH_W'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RCHK,
        ST_RMUL,
        ST_RDIV,
        ST_TSTART,
        ST_TMUL,
        ST_TDIV,
        ST_DONE
    } state_t;

    // sequencer
    state_t              state_reg, state_next;
    logic [CH_W-1:0]     ch_reg, ch_next;
    logic                ramp_mode_reg, ramp_mode_next;
    logic                rsp_valid_reg, rsp_valid_next;
    rsp_t                rsp_data_reg, rsp_data_next;

    // configuration registers
    logic [PERIOD_W-1:0] period_reg, period_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    // per-channel state
    logic [PERIOD_W-1:0] tick_reg     [CHANNELS];
    logic [PERIOD_W-1:0] tick_next    [CHANNELS];
    logic                pin_reg      [CHANNELS];
    logic                pin_next     [CHANNELS];
    logic [DUTY_W-1:0]   duty_reg     [CHANNELS];
    logic [DUTY_W-1:0]   duty_next    [CHANNELS];
    logic [DUTY_W-1:0]   cap_reg      [CHANNELS];
    logic [DUTY_W-1:0]   cap_next     [CHANNELS];
    logic [MS_W-1:0]     elapsed_reg  [CHANNELS];
    logic [MS_W-1:0]     elapsed_next [CHANNELS];
    logic [MS_W-1:0]     ramp_reg     [CHANNELS];
    logic [MS_W-1:0]     ramp_next    [CHANNELS];
    logic [PERIOD_W-1:0] thr_reg      [CHANNELS];
    logic [PERIOD_W-1:0] thr_next     [CHANNELS];
    logic [DIR_W-1:0]    dir_reg      [CHANNELS];
    logic [DIR_W-1:0]    dir_next     [CHANNELS];

    // pwm tick lanes
    logic [PERIOD_W-1:0] tick_inc  [CHANNELS];
    logic [PERIOD_W-1:0] tick_wrap [CHANNELS];
    logic                pin_new   [CHANNELS];

    // serial arithmetic
    logic                mul_start, mul_done;
    logic [MUL_A_W-1:0]  mul_a;
    logic [MUL_B_W-1:0]  mul_b;
    logic [MUL_P_W-1:0]  mul_product;
    logic                div_start, div_done;
    logic [DIV_D_W-1:0]  div_d;
    logic [DIV_N_W-1:0]  div_quotient;

    // selected channel and decoded request
    logic [DUTY_W-1:0]   sel_duty, sel_cap, new_duty;
    logic [MS_W-1:0]     sel_elapsed, sel_ramp, elapsed_sum, ramp_ms_new;
    logic [DUTY_W-1:0]   cap_new;
    logic                q_over, cmd_ok, last_ch;
    logic [CH_W-1:0]     cmd_ch;
    state_t              adv_state;
    rsp_t                rsp_snap;

    assign sel_duty    = duty_reg[ch_reg];
    assign sel_cap     = cap_reg[ch_reg];
    assign sel_elapsed = elapsed_reg[ch_reg];
    assign sel_ramp    = ramp_reg[ch_reg];
    assign elapsed_sum = sel_elapsed + MS_W'(step_reg);

    // quotient of the ramp divide, capped at the duty limit
    assign q_over   = (|div_quotient[DIV_N_W-1:DUTY_W])
                   || (div_quotient[DUTY_W-1:0] > sel_cap);
    assign new_duty = q_over ? sel_cap : div_quotient[DUTY_W-1:0];

    // seconds times 1000 as 1024 - 16 - 8
    assign ramp_ms_new = {req_data.ramp_seconds, 10'b0}
                       - MS_W'({req_data.ramp_seconds, 4'b0})
                       - MS_W'({req_data.ramp_seconds, 3'b0});
    assign cap_new     = (req_data.duty_limit > DUTY_MAX) ? DUTY_MAX : req_data.duty_limit;
    assign cmd_ok      = HAS_B || (req_data.channel == 1'b0);
    assign cmd_ch      = CH_W'(req_data.channel);

    // walking to the next channel of a ramp or threshold sweep
    assign last_ch   = (ch_reg == CH_LAST);
    assign adv_state = last_ch ? (ramp_mode_reg ? ST_DONE : ST_IDLE)
                               : (ramp_mode_reg ? ST_RCHK : ST_TSTART);

    // multiplier takes elapsed x cap for the ramp, period x duty for the threshold
    assign mul_a = (state_reg == ST_TSTART) ? MUL_A_W'(period_reg) : elapsed_sum;
    assign mul_b = (state_reg == ST_TSTART) ? sel_duty : sel_cap;
    assign div_d = (state_reg == ST_TMUL) ? PCT_DIV : sel_ramp;

    sspmd_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_product)
    );

    sspmd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mul_product),
        .divisor  (div_d),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // pwm counter lanes, one per channel
    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            tick_inc[c]  = tick_reg[c] + PERIOD_W'(1);
            tick_wrap[c] = (tick_inc[c] >= period_reg) ? '0 : tick_inc[c];
            pin_new[c]   = (tick_wrap[c] < thr_reg[c]);
        end
    end

    // result snapshot, missing second channel reads as zero
    always_comb
    begin
        rsp_snap.pwm_a  = pin_reg[0];
        rsp_snap.dir_a  = dir_reg[0];
        rsp_snap.duty_a = duty_reg[0];
        rsp_snap.pwm_b  = HAS_B ? pin_reg[B_IDX] : 1'b0;
        rsp_snap.dir_b  = HAS_B ? dir_reg[B_IDX] : DIR_OFF;
        rsp_snap.duty_b = HAS_B ? duty_reg[B_IDX] : '0;
    end

    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        ramp_mode_next = ramp_mode_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_data_next  = rsp_data_reg;
        period_next    = period_reg;
        step_next      = step_reg;
        tick_next      = tick_reg;
        pin_next       = pin_reg;
        duty_next      = duty_reg;
        cap_next       = cap_reg;
        elapsed_next   = elapsed_reg;
        ramp_next      = ramp_reg;
        thr_next       = thr_reg;
        dir_next       = dir_reg;
        mul_start      = 1'b0;
        div_start      = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    case (cfg_index)
                        CFG_PERIOD:
                        begin
                            // new period: rebuild every threshold
                            period_next    = cfg_data[PERIOD_W-1:0];
                            ch_next        = '0;
                            ramp_mode_next = 1'b0;
                            state_next     = ST_TSTART;
                        end
                        CFG_STEP:
                        begin
                            step_next = cfg_data[STEP_W-1:0];
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else if (req_valid)
                begin
                    state_next = ST_DONE;
                    case (req_data.func)
                        FN_PWM:
                        begin
                            tick_next = tick_wrap;
                            pin_next  = pin_new;
                        end
                        FN_RAMP:
                        begin
                            ch_next        = '0;
                            ramp_mode_next = 1'b1;
                            state_next     = ST_RCHK;
                        end
                        FN_FWD, FN_BWD:
                        begin
                            // restart from zero duty, so the threshold is zero too
                            if (cmd_ok)
                            begin
                                dir_next[cmd_ch]     = (req_data.func == FN_FWD) ? DIR_FWD
                                                                                 : DIR_BWD;
                                duty_next[cmd_ch]    = '0;
                                elapsed_next[cmd_ch] = '0;
                                ramp_next[cmd_ch]    = ramp_ms_new;
                                cap_next[cmd_ch]     = cap_new;
                                thr_next[cmd_ch]     = '0;
                            end
                        end
                        FN_STOP:
                        begin
                            // duty limit is kept
                            if (cmd_ok)
                            begin
                                dir_next[cmd_ch]     = DIR_OFF;
                                duty_next[cmd_ch]    = '0;
                                elapsed_next[cmd_ch] = '0;
                                ramp_next[cmd_ch]    = '0;
                                thr_next[cmd_ch]     = '0;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_RCHK:
            begin
                // ramp idle or finished: skip this channel
                if ((sel_ramp == '0) || (sel_elapsed > sel_ramp))
                begin
                    state_next = adv_state;
                    ch_next    = last_ch ? ch_reg : ch_reg + CH_ONE;
                end
                else
                begin
                    elapsed_next[ch_reg] = elapsed_sum;
                    mul_start            = 1'b1;
                    state_next           = ST_RMUL;
                end
            end

            ST_RMUL:
            begin
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_RDIV;
                end
            end

            ST_RDIV:
            begin
                if (div_done)
                begin
                    if (new_duty != sel_duty)
                    begin
                        duty_next[ch_reg] = new_duty;
                        state_next        = ST_TSTART;
                    end
                    else
                    begin
                        state_next = adv_state;
                        ch_next    = last_ch ? ch_reg : ch_reg + CH_ONE;
                    end
                end
            end

            ST_TSTART:
            begin
                mul_start  = 1'b1;
                state_next = ST_TMUL;
            end

            ST_TMUL:
            begin
                if (mul_done)
                begin
                    div_start  = 1'b1;
                    state_next = ST_TDIV;
                end
            end

            ST_TDIV:
            begin
                if (div_done)
                begin
                    thr_next[ch_reg] = div_quotient[PERIOD_W-1:0];
                    state_next       = adv_state;
                    ch_next          = last_ch ? ch_reg : ch_reg + CH_ONE;
                end
            end

            ST_DONE:
            begin
                // hold the result until the output register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_data_next  = rsp_snap;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ch_reg        <= '0;
            ramp_mode_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            ch_reg        <= ch_next;
            ramp_mode_reg <= ramp_mode_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_data_reg  <= rsp_data_next;
        end
    end

    // configuration and channel state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RST;
            step_reg   <= STEP_RST;
            for (int c = 0; c < CHANNELS; c++)
            begin
                tick_reg[c]    <= '0;
                pin_reg[c]     <= 1'b0;
                duty_reg[c]    <= '0;
                cap_reg[c]     <= '0;
                elapsed_reg[c] <= '0;
                ramp_reg[c]    <= '0;
                thr_reg[c]     <= '0;
                dir_reg[c]     <= DIR_OFF;
            end
        end
        else
        begin
            period_reg  <= period_next;
            step_reg    <= step_next;
            tick_reg    <= tick_next;
            pin_reg     <= pin_next;
            duty_reg    <= duty_next;
            cap_reg     <= cap_next;
            elapsed_reg <= elapsed_next;
            ramp_reg    <= ramp_next;
            thr_reg     <= thr_next;
            dir_reg     <= dir_next;
        end
    end

    // configuration wins over a request in the same idle cycle
    assign cfg_ready = (state_reg == ST_IDLE);
    assign req_ready = (state_reg == ST_IDLE) && !cfg_valid;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    // every accepted request leaves idle
    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg != ST_IDLE))
        else $error("accepted request did not start work");

    // serial units only finish while the sequencer waits for them
    a_mul_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> ((state_reg == ST_RMUL) || (state_reg == ST_TMUL)))
        else $error("multiplier finished outside a wait state");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> ((state_reg == ST_RDIV) || (state_reg == ST_TDIV)))
        else $error("divider finished outside a wait state");

    // channel 0 duty never passes its limit, limit never passes 100
    a_duty_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (duty_reg[0] <= cap_reg[0]) && (cap_reg[0] <= DUTY_MAX))
        else $error("duty above its limit");

    // channel 0 threshold is a fraction of the period once the sequencer rests
    a_thr_period: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (thr_reg[0] <= period_reg))
        else $error("threshold above period");

endmodule

`default_nettype wire
